@@ rtl/core/tqwps_pkg.sv @@
// Shared types and constants for the two-queue weighted priority server.
// Used by the front, the command queue, the back and the top level.
// No dependencies.
`default_nettype none

package tqwps_pkg;

  localparam int VALUE_W         = 32;
  localparam int LIMIT_W         = 8;
  localparam int IN_USER_W       = 2;
  localparam int OUT_USER_W      = 3;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CQ_DEPTH        = 2;
  localparam int CQ_PTR_W        = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W        = $clog2(CQ_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RESET = 8'd4;
  localparam logic [LIMIT_W-1:0] BURST_MAX         = 8'hFF;

  // Command encoding on the input tuser bit 0
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVE   = 1'b1;

  // Queue selector on the input tuser bit 1
  localparam logic SEL_PREF = 1'b0;
  localparam logic SEL_NORM = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH_PREF = 2'd0,
    OP_PUSH_NORM = 2'd1,
    OP_SERVE     = 2'd2
  } tqwps_op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } tqwps_status_e;

  typedef struct packed {
    tqwps_op_e                  op;
    logic signed [VALUE_W-1:0]  value;
  } tqwps_cmd_t;

  typedef struct packed {
    logic norm_empty;
    logic norm_full;
    logic pref_empty;
    logic pref_full;
  } tqwps_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/tqwps_front.sv @@
// Front end: accepts input words and classifies them into commands.
// Depends on tqwps_pkg.
`default_nettype none

module tqwps_front (
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [tqwps_pkg::VALUE_W-1:0]      s_axis_tdata,
  input  wire logic [tqwps_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                    push_o,
  output tqwps_pkg::tqwps_cmd_t                   cmd_o,
  input  wire logic                               queue_ready_i
);
  import tqwps_pkg::*;

  // Decode command kind and target queue.
  always_comb begin
    cmd_o.value = s_axis_tdata;
    unique case (s_axis_tuser[0])
      CMD_SERVE: cmd_o.op = OP_SERVE;
      CMD_ENQUEUE: begin
        cmd_o.op = (s_axis_tuser[1] == SEL_NORM) ? OP_PUSH_NORM : OP_PUSH_PREF;
      end
      default: cmd_o.op = OP_SERVE;
    endcase
  end

  assign s_axis_tready = queue_ready_i;
  assign push_o        = s_axis_tvalid && queue_ready_i;

endmodule

`default_nettype wire

@@ rtl/core/tqwps_cmd_queue.sv @@
// Short command queue between the front and the back end.
// Depends on tqwps_pkg.
`default_nettype none

module tqwps_cmd_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire tqwps_pkg::tqwps_cmd_t  cmd_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output tqwps_pkg::tqwps_cmd_t       cmd_o,
  input  wire logic                   pop_i
);
  import tqwps_pkg::*;

  tqwps_cmd_t            slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  do_pop;

  assign ready_o = (cnt_q != CQ_CNT_W'(CQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + CQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + CQ_PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CQ_CNT_W'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload slots: hold until overwritten.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tqwps_back.sv @@
// Back end: the two value FIFOs, the burst arbiter and the result register.
// Depends on tqwps_pkg.
`default_nettype none

module tqwps_back #(
  parameter int QUEUE_DEPTH = tqwps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cmd_valid_i,
  input  wire tqwps_pkg::tqwps_cmd_t              cmd_i,
  output logic                                    cmd_ready_o,
  input  wire logic [tqwps_pkg::LIMIT_W-1:0]      limit_i,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [tqwps_pkg::VALUE_W-1:0]           m_axis_tdata,
  output logic [tqwps_pkg::OUT_USER_W-1:0]        m_axis_tuser,
  output tqwps_pkg::tqwps_stat_t                  stat_o
);
  import tqwps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_W-1:0]  norm_mem [QUEUE_DEPTH];
  logic [VALUE_W-1:0]  pref_mem [QUEUE_DEPTH];
  logic [VALUE_W-1:0]  norm_rd_q, pref_rd_q;

  logic [PTR_W-1:0]    norm_head_q, norm_head_d, norm_tail_q, norm_tail_d;
  logic [PTR_W-1:0]    pref_head_q, pref_head_d, pref_tail_q, pref_tail_d;
  logic [CNT_W-1:0]    norm_cnt_q, norm_cnt_d, pref_cnt_q, pref_cnt_d;
  logic [LIMIT_W-1:0]  burst_q, burst_d;

  logic                res_valid_q;
  tqwps_status_e       res_status_q, status;
  logic                res_from_q, from;
  logic                exec;
  logic                norm_wr, pref_wr, norm_rd, pref_rd;

  assign stat_o.norm_empty = (norm_cnt_q == '0);
  assign stat_o.pref_empty = (pref_cnt_q == '0);
  assign stat_o.norm_full  = (norm_cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.pref_full  = (pref_cnt_q == CNT_W'(QUEUE_DEPTH));

  assign cmd_ready_o = !res_valid_q || m_axis_tready;
  assign exec        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    status  = ST_EMPTY;
    from    = SEL_PREF;
    norm_wr = 1'b0;
    pref_wr = 1'b0;
    norm_rd = 1'b0;
    pref_rd = 1'b0;
    burst_d = burst_q;
    unique case (cmd_i.op)
      OP_PUSH_NORM: begin
        if (stat_o.norm_full) begin
          status = ST_FULL;
        end else begin
          status  = ST_ENQUEUED;
          norm_wr = exec;
        end
      end
      OP_PUSH_PREF: begin
        if (stat_o.pref_full) begin
          status = ST_FULL;
        end else begin
          status  = ST_ENQUEUED;
          pref_wr = exec;
        end
      end
      OP_SERVE: begin
        if (stat_o.norm_empty && stat_o.pref_empty) begin
          status = ST_EMPTY;
        end else begin
          status = ST_SERVED;
          if (stat_o.pref_empty) begin
            from = SEL_NORM;
          end else if (stat_o.norm_empty) begin
            from = SEL_PREF;
          end else if (burst_q > limit_i) begin
            from = SEL_NORM;
            if (exec) begin
              burst_d = '0;
            end
          end else begin
            from = SEL_PREF;
            if (exec && (burst_q != BURST_MAX)) begin
              burst_d = burst_q + LIMIT_W'(1);
            end
          end
          norm_rd = exec && (from == SEL_NORM);
          pref_rd = exec && (from == SEL_PREF);
        end
      end
      default: begin
        status = ST_EMPTY;
      end
    endcase
  end

  // Pointer and count updates; wrap at the queue depth.
  always_comb begin
    norm_head_d = norm_head_q;
    norm_tail_d = norm_tail_q;
    norm_cnt_d  = norm_cnt_q;
    pref_head_d = pref_head_q;
    pref_tail_d = pref_tail_q;
    pref_cnt_d  = pref_cnt_q;
    if (norm_wr) begin
      norm_tail_d = (norm_tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : norm_tail_q + PTR_W'(1);
      norm_cnt_d  = norm_cnt_q + CNT_W'(1);
    end
    if (norm_rd) begin
      norm_head_d = (norm_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : norm_head_q + PTR_W'(1);
      norm_cnt_d  = norm_cnt_q - CNT_W'(1);
    end
    if (pref_wr) begin
      pref_tail_d = (pref_tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pref_tail_q + PTR_W'(1);
      pref_cnt_d  = pref_cnt_q + CNT_W'(1);
    end
    if (pref_rd) begin
      pref_head_d = (pref_head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pref_head_q + PTR_W'(1);
      pref_cnt_d  = pref_cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_head_q <= '0;
      norm_tail_q <= '0;
      norm_cnt_q  <= '0;
      pref_head_q <= '0;
      pref_tail_q <= '0;
      pref_cnt_q  <= '0;
      burst_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      norm_head_q <= norm_head_d;
      norm_tail_q <= norm_tail_d;
      norm_cnt_q  <= norm_cnt_d;
      pref_head_q <= pref_head_d;
      pref_tail_q <= pref_tail_d;
      pref_cnt_q  <= pref_cnt_d;
      burst_q     <= burst_d;
      if (exec) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_status_q <= status;
      res_from_q   <= from;
    end
  end

  // Value memories: one write and one registered read a cycle each.
  always_ff @(posedge clk_i) begin
    if (norm_wr) begin
      norm_mem[norm_tail_q] <= cmd_i.value;
    end
    if (norm_rd) begin
      norm_rd_q <= norm_mem[norm_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pref_wr) begin
      pref_mem[pref_tail_q] <= cmd_i.value;
    end
    if (pref_rd) begin
      pref_rd_q <= pref_mem[pref_head_q];
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = {res_from_q, res_status_q};
  assign m_axis_tdata  = (res_status_q != ST_SERVED) ? '0 :
                         ((res_from_q == SEL_NORM) ? norm_rd_q : pref_rd_q);

endmodule

`default_nettype wire

@@ rtl/core/two_queue_weighted_priority_server_unit.sv @@
// Top level of the two-queue weighted priority server.
// Instantiates tqwps_front, tqwps_cmd_queue and tqwps_back; depends on tqwps_pkg.
//
// Usage:
//   Input words arrive on the s_axis channel. tuser[0] picks the command
//   (enqueue or serve), tuser[1] picks the target queue for an enqueue
//   (normal or preferential), tdata carries the signed value.
//   Every input word yields exactly one result word on m_axis: tuser[1:0] is
//   the status (enqueued, served, both empty, full and dropped), tuser[2] is
//   the queue served, tdata the served value (zero unless served).
//   The burst limit sits behind the cfg channel; write it only while idle.
// Timing:
//   An accepted word enters the command queue, is executed by the back end
//   and its result is registered. One word a cycle is sustained while
//   m_axis_tready stays high: the back end runs one command a cycle.
// Stalls and reset:
//   When m_axis_tready is low the result is held; the two-entry command queue
//   keeps taking words until it fills, then s_axis_tready drops.
//   Reset empties both queues, clears the burst counter and loads the burst
//   limit with its default of 4. No clearing pass is needed.
`default_nettype none

module two_queue_weighted_priority_server_unit #(
  parameter int QUEUE_DEPTH = tqwps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input words
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [tqwps_pkg::VALUE_W-1:0]      s_axis_tdata,  // [31:0] value_in
  input  wire logic [tqwps_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [0] cmd, [1] queue_select
  // Result words
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [tqwps_pkg::VALUE_W-1:0]           m_axis_tdata,  // [31:0] value_out
  output logic [tqwps_pkg::OUT_USER_W-1:0]        m_axis_tuser,  // [1:0] status, [2] served_from
  // Burst limit register write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tqwps_pkg::LIMIT_W-1:0]      cfg_data_i
);
  import tqwps_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               front_push;
  tqwps_cmd_t         front_cmd;
  logic               queue_ready;
  logic               queue_valid;
  tqwps_cmd_t         queue_cmd;
  logic               back_ready;
  tqwps_stat_t        back_stat;

  // Config register: always ready, take the word on handshake.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= BURST_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Front: classify incoming words.
  tqwps_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (front_push),
    .cmd_o         (front_cmd),
    .queue_ready_i (queue_ready)
  );

  // Decouple front and back so each can stall on its own.
  tqwps_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .ready_o (queue_ready),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (back_ready)
  );

  // Back: queues, arbitration, result register.
  tqwps_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (queue_valid),
    .cmd_i         (queue_cmd),
    .cmd_ready_o   (back_ready),
    .limit_i       (limit_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .stat_o        (back_stat)
  );

`ifndef SYNTHESIS
  // A serve with both queues empty must report empty on the next result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_valid && back_ready && (queue_cmd.op == OP_SERVE) &&
     back_stat.norm_empty && back_stat.pref_empty)
    |=> (m_axis_tvalid && (m_axis_tuser[1:0] == ST_EMPTY)))
    else $error("serve on empty queues not reported as empty");

  // An enqueue into a full normal queue must be dropped and flagged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_valid && back_ready && (queue_cmd.op == OP_PUSH_NORM) && back_stat.norm_full)
    |=> (m_axis_tvalid && (m_axis_tuser[1:0] == ST_FULL) && back_stat.norm_full))
    else $error("enqueue into full normal queue not flagged");

  // Only a served result carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[1:0] != ST_SERVED)) |-> (m_axis_tdata == '0))
    else $error("nonzero value on a result that was not served");

  // A queue can never be empty and full at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(back_stat.norm_empty && back_stat.norm_full) &&
    !(back_stat.pref_empty && back_stat.pref_full))
    else $error("queue fill state inconsistent");
`endif

endmodule

`default_nettype wire
